FILE: hw/rtl/bmop_pkg.sv
// ----------------------------------------------------------------------------
// bmop_pkg
// Shared types and constants of the binary mask OR pyramid.
// ----------------------------------------------------------------------------
package bmop_pkg;

    localparam int COL_W   = 13;  // base column, wide enough for the largest width
    localparam int ROW_W   = 16;  // base row
    localparam int LVL_N   = 5;   // output levels the hardware can hold
    localparam int LEVEL_W = 3;
    localparam int OCOL_W  = 9;
    localparam int OROW_W  = 15;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_REQUEST = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // frame geometry as seen by the front
    typedef struct packed {
        logic [COL_W-1:0] w_m1;   // effective width minus one
        logic [ROW_W-1:0] h_m1;   // effective height minus one
        logic [2:0]       reqc;   // clamped level request
    } bmop_geom_t;

    // one classified pixel
    typedef struct packed {
        logic             pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [LVL_N-1:0] touch;  // level sees the value from below
        logic [LVL_N-1:0] emit;   // level produces a result
        logic [LVL_N-1:0] wr;     // level stores the upper-row pair
        logic [LVL_N-1:0] rd;     // level merges the stored upper-row pair
    } bmop_desc_t;

endpackage

FILE: hw/rtl/bmop_front.sv
// ----------------------------------------------------------------------------
// bmop_front
// Accepts base pixels, tracks the raster position and classifies each level.
// ----------------------------------------------------------------------------
module bmop_front import bmop_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       restart,
    input  bmop_geom_t geom,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       pixel_in,
    input  logic       q_full,
    output logic       push,
    output bmop_desc_t push_desc
);

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        logic [COL_W-1:0] cs;
        logic [COL_W-1:0] ws;
        logic [ROW_W-1:0] rs;
        logic [ROW_W-1:0] hs;
        logic             en;
        logic             col_done;
        logic             row_wr;
        logic             prev;
        prev = 1'b1;
        push_desc.pixel = pixel_in;
        push_desc.col   = col_reg;
        push_desc.row   = row_reg;
        for (int i = 0; i < LVL_N; i++) begin
            cs = col_reg >> i;
            ws = geom.w_m1 >> i;
            rs = row_reg >> i;
            hs = geom.h_m1 >> i;
            // level exists if requested and the level below is not yet 1x1
            en       = (geom.reqc > 3'(i + 1)) && ((ws != '0) || (hs != '0));
            col_done = cs[0] || (cs == ws);
            row_wr   = !rs[0] && (rs != hs);
            push_desc.touch[i] = en && prev;
            push_desc.emit[i]  = en && prev && col_done && !row_wr;
            push_desc.wr[i]    = en && prev && col_done && row_wr;
            push_desc.rd[i]    = en && prev && col_done && rs[0];
            prev = push_desc.emit[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (push) begin
            if (col_reg == geom.w_m1) begin
                col_reg <= '0;
                row_reg <= (row_reg == geom.h_m1) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/bmop_queue.sv
// ----------------------------------------------------------------------------
// bmop_queue
// Short register queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module bmop_queue import bmop_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  bmop_desc_t push_desc,
    input  logic       pop,
    output logic       full,
    output logic       q_valid,
    output bmop_desc_t q_desc
);

    bmop_desc_t        buf_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_desc  = buf_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W + 1)'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    ap_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

FILE: hw/rtl/bmop_back.sv
// ----------------------------------------------------------------------------
// bmop_back
// Runs the level cascade: row store reads, pair ORs, and result emission.
// ----------------------------------------------------------------------------
module bmop_back import bmop_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int LEVEL_CAP = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 restart,
    input  logic                 q_valid,
    input  bmop_desc_t           q_desc,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int NL = LEVEL_CAP - 1;

    logic             a_valid_reg;
    bmop_desc_t       a_desc_reg;
    logic [LVL_N-1:0] pair_reg;
    logic [LVL_N-1:0] e_mask_reg;
    logic [LVL_N-1:0] e_hit_reg;
    logic [COL_W-1:0] e_col_reg;
    logic [ROW_W-1:0] e_row_reg;

    logic [LVL_N-1:0] stored;
    logic [LVL_N-1:0] p_val;
    logic [LVL_N-1:0] hit_val;
    logic [LVL_N-1:0] e_rest;
    logic             e_free;
    logic             a_adv;
    logic [2:0]       sel;
    logic [2:0]       out_level;
    logic             out_hit;
    logic [COL_W+OCOL_W-1:0] col_sh;
    logic [ROW_W-1:0]        row_sh;

    assign e_rest   = e_mask_reg & (e_mask_reg - LVL_N'(1));
    assign m_tvalid = (e_mask_reg != '0);
    assign m_tlast  = (e_rest == '0);
    assign e_free   = !m_tvalid || (m_tready && (e_rest == '0));
    assign a_adv    = a_valid_reg && e_free;
    assign pop      = q_valid && (!a_valid_reg || e_free);

    // per-level row stores, read when an item enters stage a
    for (genvar g = 0; g < LVL_N; g++) begin : g_lvl
        if (g < NL) begin : g_mem
            localparam int DEPTH = (MAX_WIDTH + (1 << (g + 1)) - 1) >> (g + 1);
            localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

            logic             mem [DEPTH];
            logic [COL_W-1:0] rd_sh;
            logic [COL_W-1:0] wr_sh;
            logic [AW-1:0]    rd_addr;
            logic [AW-1:0]    wr_addr;
            logic             rdq_reg;
            logic             fwd_hit_reg;
            logic             fwd_data_reg;

            assign rd_sh   = q_desc.col >> (g + 1);
            assign wr_sh   = a_desc_reg.col >> (g + 1);
            assign rd_addr = rd_sh[AW-1:0];
            assign wr_addr = wr_sh[AW-1:0];

            always_ff @(posedge aclk) begin
                if (a_adv && a_desc_reg.wr[g]) begin
                    mem[wr_addr] <= p_val[g];
                end
                if (pop) begin
                    rdq_reg      <= mem[rd_addr];
                    // same-cycle write from the item ahead wins
                    fwd_hit_reg  <= a_adv && a_desc_reg.wr[g] && (wr_addr == rd_addr);
                    fwd_data_reg <= p_val[g];
                end
            end

            assign stored[g] = fwd_hit_reg ? fwd_data_reg : rdq_reg;
        end else begin : g_none
            assign stored[g] = 1'b0;
        end
    end

    always_comb begin
        logic v;
        v = a_desc_reg.pixel;
        for (int i = 0; i < LVL_N; i++) begin
            p_val[i]   = pair_reg[i] | v;
            hit_val[i] = p_val[i] | (a_desc_reg.rd[i] & stored[i]);
            v = hit_val[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (pop) begin
            a_valid_reg <= 1'b1;
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            a_desc_reg <= q_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg <= '0;
        end else if (restart) begin
            pair_reg <= '0;
        end else if (a_adv) begin
            for (int i = 0; i < LVL_N; i++) begin
                if (a_desc_reg.touch[i]) begin
                    pair_reg[i] <= (a_desc_reg.emit[i] || a_desc_reg.wr[i]) ? 1'b0 : p_val[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_mask_reg <= '0;
        end else if (a_adv) begin
            e_mask_reg <= a_desc_reg.emit;
        end else if (m_tvalid && m_tready) begin
            e_mask_reg <= e_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            e_hit_reg <= hit_val;
            e_col_reg <= a_desc_reg.col;
            e_row_reg <= a_desc_reg.row;
        end
    end

    // lowest pending level goes out first
    always_comb begin
        sel = '0;
        for (int i = LVL_N - 1; i >= 0; i--) begin
            if (e_mask_reg[i]) begin
                sel = 3'(i);
            end
        end
    end

    assign out_level = sel + 3'd1;
    assign out_hit   = e_hit_reg[sel];
    assign col_sh    = {{OCOL_W{1'b0}}, e_col_reg} >> out_level;
    assign row_sh    = e_row_reg >> out_level;
    assign m_tdata   = {{(M_TDATA_W - LEVEL_W - OCOL_W - OROW_W - 1){1'b0}},
                        out_hit, row_sh[OROW_W-1:0], col_sh[OCOL_W-1:0], out_level};

`ifndef NO_ASSERTIONS
    ap_emit_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |-> (((a_desc_reg.emit >> 1) & ~a_desc_reg.emit) == '0))
        else $error("emit levels not contiguous from level one");

    ap_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |-> $onehot0(a_desc_reg.wr))
        else $error("more than one row store write for one pixel");

    ap_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (out_level == $past(out_level) + 3'd1)))
        else $error("run of results broken before its last transfer");
`endif

endmodule

FILE: hw/rtl/binary_mask_or_pyramid.sv
// ----------------------------------------------------------------------------
// binary_mask_or_pyramid
// Streams the coarser 2x2 OR levels of a binary mask given in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one base pixel per transfer (s_tdata bit 0), row by row.
//   m_* gives every level pixel that the pixel completes, lowest level
//   first; m_tlast marks the final result of that pixel. Pixels that
//   complete nothing give no transfer.
//   cfg_* writes image_width (0), image_height (1), level_request (2);
//   cfg_ready is always high. A write to these restarts the frame at (0,0).
//   The user must write only while the block is idle; it is not enforced.
// Timing:
//   a pixel enters a four-entry queue, passes the row store read stage, then
//   its results sit in the output register. One pixel per cycle is taken
//   while the queue has room; a pixel with n results holds the output
//   register for n transfers, so the output port sets the rate when many
//   levels finish together.
// Reset clears position, pair state and pipeline; the row stores need no
// clearing. When m_tready is low the queue fills and s_tready falls.
// ----------------------------------------------------------------------------
module binary_mask_or_pyramid import bmop_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int LEVEL_CAP = 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,    // [0] pixel_bit
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,    // [2:0] level, [11:3] column,
                                               // [26:12] row, [27] hit
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [10:0]      width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [2:0]       req_reg;

    logic             cfg_we;
    logic             restart;
    logic [13:0]      width_ext;
    logic [13:0]      w_eff_m1;
    bmop_geom_t       geom;

    logic             push;
    bmop_desc_t       push_desc;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    bmop_desc_t       q_desc;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb begin
        unique case (cfg_index)
            CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_LEVEL_REQUEST: restart = cfg_we;
            default: restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd1;
            height_reg <= 16'd1;
            req_reg    <= 3'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                CFG_LEVEL_REQUEST: req_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // zero width counts as one, wide images clamp to the line store size
    assign width_ext = {3'b000, width_reg};
    assign w_eff_m1  = (width_ext == '0)              ? '0 :
                       (width_ext > 14'(MAX_WIDTH))   ? 14'(MAX_WIDTH - 1) :
                                                        width_ext - 14'd1;

    assign geom.w_m1 = w_eff_m1[COL_W-1:0];
    assign geom.h_m1 = (height_reg == '0) ? '0 : height_reg - ROW_W'(1);
    assign geom.reqc = (req_reg > 3'(LEVEL_CAP)) ? 3'(LEVEL_CAP) : req_reg;

    bmop_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .geom      (geom),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .pixel_in  (s_tdata[0]),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    bmop_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_desc    (q_desc)
    );

    bmop_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .LEVEL_CAP (LEVEL_CAP)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (restart),
        .q_valid  (q_valid),
        .q_desc   (q_desc),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: tb/sv/binary_mask_or_pyramid_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_mask_or_pyramid_tb
// Streams binary mask pixels into the pyramid block under random handshake
// gaps on both sides. A behavioral copy of the 2x2 OR cascade predicts every
// level pixel, and each output transfer is checked against the oldest
// prediction. Frame geometry and level count are changed between bursts
// while the block is drained.
// ----------------------------------------------------------------------------
module binary_mask_or_pyramid_tb;
    import bmop_pkg::*;

    localparam int MAXW    = 1024;
    localparam int MAXL    = 6;
    localparam int STORE_N = MAXW + MAXL;

    // index 3 names no register: the block must ignore it
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [OCOL_W-1:0]  column;
        logic [OROW_W-1:0]  row;
        logic               hit;
        logic               end_of_run;
    } lvl_pix_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // [0] pixel_bit
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;    // [2:0] level, [11:3] column,
                                        // [26:12] row, [27] hit
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bit       pixel_q[$];
    lvl_pix_t level_pix_q[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    int       errors;

    // predictor state
    int unsigned reg_width;
    int unsigned reg_height;
    int unsigned reg_req;
    int unsigned pos_col;
    int unsigned pos_row;
    bit          pair_or [0:MAXL-1];
    bit          row_or  [0:STORE_N-1];

    binary_mask_or_pyramid DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned eff_w();
        if (reg_width == 0) return 1;
        if (reg_width > MAXW) return MAXW;
        return reg_width;
    endfunction

    function automatic int unsigned eff_h();
        return (reg_height == 0) ? 1 : reg_height;
    endfunction

    // levels counting the base, cut at the first 1x1 level
    function automatic int unsigned level_count();
        int unsigned req;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        req = reg_req;
        w = eff_w();
        h = eff_h();
        n = 1;
        if (req <= 1) return 1;
        if (req > MAXL) req = MAXL;
        while (w > 1 || h > 1) begin
            w = (w + 1) >> 1;
            h = (h + 1) >> 1;
            n++;
            if (n >= req) break;
        end
        return n;
    endfunction

    function automatic int unsigned region_start(input int unsigned k);
        int unsigned off;
        off = 0;
        for (int unsigned j = 1; j < k; j++)
            off += (MAXW + (1 << j) - 1) >> j;
        return off;
    endfunction

    function automatic void restart_frame();
        pos_col = 0;
        pos_row = 0;
        for (int i = 0; i < MAXL; i++) pair_or[i] = 1'b0;
    endfunction

    function automatic void predict_pixel(input bit pix);
        int unsigned w;
        int unsigned h;
        int unsigned nlev;
        int unsigned c;
        int unsigned r;
        int unsigned cw;
        int unsigned ch;
        int unsigned slot;
        int unsigned k;
        int          n;
        bit          v;
        bit          p;
        lvl_pix_t    run_buf [0:LVL_N-1];
        lvl_pix_t    res;
        w = eff_w();
        h = eff_h();
        nlev = level_count();
        c = pos_col;
        r = pos_row;
        cw = w;
        ch = h;
        v = pix;
        n = 0;
        for (k = 1; k < nlev; k++) begin
            pair_or[k-1] = pair_or[k-1] | v;
            // a pair closes on an odd column or at a clipped right edge
            if (!((c & 1) != 0 || c == cw - 1)) break;
            p = pair_or[k-1];
            pair_or[k-1] = 1'b0;
            slot = region_start(k) + (c >> 1);
            if ((r & 1) == 0 && r != ch - 1) begin
                // upper row of the block: park the pair for the row below
                if (slot < STORE_N) row_or[slot] = p;
                break;
            end
            if ((r & 1) != 0 && slot < STORE_N) p = p | row_or[slot];
            c = c >> 1;
            r = r >> 1;
            cw = (cw + 1) >> 1;
            ch = (ch + 1) >> 1;
            res.level      = k[LEVEL_W-1:0];
            res.column     = c[OCOL_W-1:0];
            res.row        = r[OROW_W-1:0];
            res.hit        = p;
            res.end_of_run = 1'b0;
            run_buf[n] = res;
            n++;
            v = p;
        end
        for (int i = 0; i < n; i++) begin
            res = run_buf[i];
            res.end_of_run = (i == n - 1);
            level_pix_q.push_back(res);
        end
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h) pos_row = 0;
        end
    endfunction

    // driver: offers queued pixels, predicts on each accepted transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) predict_pixel(s_tdata[0]);
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W-1){1'b0}}, pixel_q.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each output transfer against the oldest prediction
    always @(posedge aclk) begin : monitor
        lvl_pix_t got;
        lvl_pix_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.level      = m_tdata[2:0];
                got.column     = m_tdata[11:3];
                got.row        = m_tdata[26:12];
                got.hit        = m_tdata[27];
                got.end_of_run = m_tlast;
                if (level_pix_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer: lvl %0d col %0d row %0d hit %0d last %0d",
                                 got.level, got.column, got.row, got.hit, got.end_of_run);
                end else begin
                    want = level_pix_q.pop_front();
                    if (got.level !== want.level || got.column !== want.column ||
                        got.row !== want.row || got.hit !== want.hit ||
                        got.end_of_run !== want.end_of_run) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: want lvl %0d col %0d row %0d hit %0d last %0d, %s",
                                     want.level, want.column, want.row, want.hit,
                                     want.end_of_run,
                                     $sformatf("got lvl %0d col %0d row %0d hit %0d last %0d",
                                               got.level, got.column, got.row, got.hit,
                                               got.end_of_run));
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // all pixels accepted, all results seen, pipeline flushed
    task automatic wait_idle();
        do @(posedge aclk); while (pixel_q.size() != 0 || s_tvalid);
        while (level_pix_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:   reg_width  = val[10:0];
            CFG_IMAGE_HEIGHT:  reg_height = val;
            CFG_LEVEL_REQUEST: reg_req    = val[2:0];
            default: ;
        endcase
        if (idx != CFG_UNUSED_INDEX) restart_frame();
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] wd,
                             input logic [CFG_DATA_W-1:0] hd,
                             input logic [CFG_DATA_W-1:0] rq);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, wd);
        write_reg(CFG_IMAGE_HEIGHT, hd);
        write_reg(CFG_LEVEL_REQUEST, rq);
    endtask

    task automatic push_random(input int count, input int density_pct);
        for (int i = 0; i < count; i++)
            pixel_q.push_back($urandom_range(99) < density_pct);
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;
        logic [CFG_DATA_W-1:0] rq;
        int unsigned ew;
        int unsigned eh;
        int          cnt;
        int          density;
        int          counted;
        int          phase;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 15;
        recv_idle_pct = 84;
        errors        = 0;
        reg_width     = 1;
        reg_height    = 1;
        reg_req       = 1;
        restart_frame();
        for (int i = 0; i < STORE_N; i++) row_or[i] = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry gives no levels
        pixel_q.push_back(1'b1);
        pixel_q.push_back(1'b0);

        // 3x3 with odd edges, request above the maximum, then wrap into a new frame
        configure(16'd3, 16'd3, 16'hFFFF);
        pixel_q.push_back(1'b1); pixel_q.push_back(1'b0); pixel_q.push_back(1'b0);
        pixel_q.push_back(1'b0); pixel_q.push_back(1'b0); pixel_q.push_back(1'b0);
        pixel_q.push_back(1'b0); pixel_q.push_back(1'b0); pixel_q.push_back(1'b1);
        pixel_q.push_back(1'b1);

        // 2x2 all clear, junk in the unused width bits
        configure(16'hF802, 16'd2, 16'd2);
        repeat (4) pixel_q.push_back(1'b0);

        // request zero: no levels
        wait_idle();
        write_reg(CFG_LEVEL_REQUEST, 16'd0);
        pixel_q.push_back(1'b1);
        pixel_q.push_back(1'b1);

        // zero width and height count as 1x1: no levels
        configure(16'd0, 16'd0, 16'd6);
        pixel_q.push_back(1'b1);
        pixel_q.push_back(1'b1);

        counted = 0;
        phase = 0;
        while (counted < 410) begin
            if (counted < 137) begin
                send_idle_pct <= 15;
                recv_idle_pct <= 84;
            end else if (counted < 274) begin
                send_idle_pct <= 84;
                recv_idle_pct <= 15;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            case ($urandom_range(3))
                0: density = 3;
                1: density = 25;
                2: density = 50;
                default: density = 92;
            endcase
            if (phase == 1) begin
                // tallest image, only its first rows
                configure(16'($urandom_range(2, 6)), 16'hFFFF, 16'd6);
                push_random(80, density);
                counted += 80;
            end else if (phase == 4) begin
                // width clamped to the maximum, start of the single row
                configure(16'h07FF, 16'd1, 16'd7);
                push_random(96, 50);
                counted += 96;
            end else begin
                wd = 16'($urandom_range(1, 12));
                if ($urandom_range(9) == 0) wd = 0;
                if ($urandom_range(3) == 0) wd[15:11] = 5'($urandom_range(31));
                hd = 16'($urandom_range(1, 8));
                if ($urandom_range(9) == 0) hd = 0;
                rq = ($urandom_range(9) < 2) ? 16'($urandom_range(1)) :
                                               16'($urandom_range(2, 7));
                if ($urandom_range(3) == 0) rq[15:3] = 13'($urandom_range(8191));
                ew = (wd[10:0] == 0) ? 1 : wd[10:0];
                eh = (hd == 0) ? 1 : hd;
                cnt = ew * eh * $urandom_range(1, 2) + $urandom_range(5);
                if (cnt > 100) cnt = 100;
                configure(wd, hd, rq);
                if (phase == 2) begin
                    // sender holds off until the block drains, mid-frame
                    push_random(cnt / 2, density);
                    wait_idle();
                    write_reg(CFG_UNUSED_INDEX, 16'($urandom_range(16'hFFFF)));
                    push_random(cnt - cnt / 2, density);
                end else begin
                    push_random(cnt, density);
                end
                counted += cnt;
            end
            phase++;
        end

        do @(posedge aclk); while (pixel_q.size() != 0 || s_tvalid);
        while (level_pix_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && level_pix_q.size() == 0) begin
            $display("binary_mask_or_pyramid_tb: clean");
        end else begin
            $display("binary_mask_or_pyramid_tb: errors");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("binary_mask_or_pyramid_tb: errors");
        $finish;
    end

endmodule
